// ===== hw/rtl/utfd_pkg.sv =====
// utfd_pkg: shared types, constants and helper functions of the UTF-8 decoder
// used by utfd_in_stage, utfd_decode, utfd_out_stage and the top level
// no dependencies
package utfd_pkg;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_MALFORMED = 2'd1,
    ST_NUL       = 2'd2,
    ST_EOS       = 2'd3
  } status_t;

  localparam int CpWidth  = 21;
  localparam int OutPosW  = 32;

  localparam logic [CpWidth-1:0] CpMax1Byte = 21'h00007F;
  localparam logic [CpWidth-1:0] CpMax2Byte = 21'h0007FF;
  localparam logic [CpWidth-1:0] CpMax3Byte = 21'h00FFFF;
  localparam logic [CpWidth-1:0] CpMaxValid = 21'h10FFFF;
  localparam logic [CpWidth-1:0] CpSurrLow  = 21'h00D800;
  localparam logic [CpWidth-1:0] CpSurrHigh = 21'h00DFFF;
  localparam logic [CpWidth-1:0] CpNewline  = 21'h00000A;

  // one result transaction as it moves from the decoder to the output register
  typedef struct packed {
    logic               valid;
    logic [CpWidth-1:0] code_point;
    status_t            status;
    logic [OutPosW-1:0] line_number;
    logic [OutPosW-1:0] column_number;
  } result_t;

  // sequence length announced by a leader byte, zero for a bad leader
  function automatic logic [2:0] lead_length(input logic [7:0] b);
    logic [2:0] len;
    len = 3'd0;
    if (b[7] == 1'b0) begin
      len = 3'd1;
    end else if (b[7:5] == 3'b110) begin
      len = 3'd2;
    end else if (b[7:4] == 4'b1110) begin
      len = 3'd3;
    end else if (b[7:3] == 5'b11110) begin
      len = 3'd4;
    end
    return len;
  endfunction

  // payload bits carried by a leader byte
  function automatic logic [CpWidth-1:0] lead_bits(input logic [7:0] b);
    logic [CpWidth-1:0] v;
    v = '0;
    if (b[7] == 1'b0) begin
      v = {13'd0, b};
    end else if (b[7:5] == 3'b110) begin
      v = {16'd0, b[4:0]};
    end else if (b[7:4] == 4'b1110) begin
      v = {17'd0, b[3:0]};
    end else begin
      v = {18'd0, b[2:0]};
    end
    return v;
  endfunction

  // length of the shortest encoding of a value
  function automatic logic [2:0] shortest_length(input logic [CpWidth-1:0] cp);
    logic [2:0] len;
    if (cp <= CpMax1Byte) begin
      len = 3'd1;
    end else if (cp <= CpMax2Byte) begin
      len = 3'd2;
    end else if (cp <= CpMax3Byte) begin
      len = 3'd3;
    end else begin
      len = 3'd4;
    end
    return len;
  endfunction

endpackage

// ===== hw/rtl/utfd_in_stage.sv =====
// utfd_in_stage: input register holding one byte transaction for the decoder
// depends on utfd_pkg (no shared items used beyond the house import)
module utfd_in_stage (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_end_of_stream,
  input  logic       step,
  output logic       held_valid,
  output logic [7:0] held_byte,
  output logic       held_eos
);
  import utfd_pkg::*;

  logic       valid_r, valid_nxt;
  logic [7:0] byte_r;
  logic       eos_r;

  // free when empty or when the held transaction is consumed this cycle
  assign in_ready = !valid_r || step;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (step) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload capture
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_data_byte;
      eos_r  <= in_end_of_stream;
    end
  end

  assign held_valid = valid_r;
  assign held_byte  = byte_r;
  assign held_eos   = eos_r;

endmodule

// ===== hw/rtl/utfd_decode.sv =====
// utfd_decode: sequence state, position counters and single-pass decode logic
// depends on utfd_pkg for status codes, result type and leader helpers
module utfd_decode #(
  parameter int POSITION_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [7:0]        data_byte,
  input  logic              end_of_stream,
  output utfd_pkg::result_t res
);
  import utfd_pkg::*;

  localparam logic [POSITION_WIDTH-1:0] PosOne = POSITION_WIDTH'(1);
  localparam logic [POSITION_WIDTH-1:0] PosMax = '1;

  logic [2:0]                exp_len_r, exp_len_nxt;
  logic [2:0]                seen_r, seen_nxt;
  logic [CpWidth-1:0]        pv_r, pv_nxt;
  logic [POSITION_WIDTH-1:0] line_r, line_nxt;
  logic [POSITION_WIDTH-1:0] col_r, col_nxt;

  logic [2:0]                lead_len;
  logic [CpWidth-1:0]        cont_pv;
  logic                      fin;
  logic [CpWidth-1:0]        fin_cp;
  logic [2:0]                fin_len;
  logic                      bad_value;
  logic [POSITION_WIDTH+OutPosW-1:0] line_ext, col_ext;

  assign lead_len = lead_length(data_byte);
  assign cont_pv  = {pv_r[CpWidth-7:0], data_byte[5:0]};
  assign line_ext = {{OutPosW{1'b0}}, line_r};
  assign col_ext  = {{OutPosW{1'b0}}, col_r};

  // decode the held byte against the pending sequence
  always_comb begin
    exp_len_nxt = exp_len_r;
    seen_nxt    = seen_r;
    pv_nxt      = pv_r;
    line_nxt    = line_r;
    col_nxt     = col_r;
    fin         = 1'b0;
    fin_cp      = '0;
    fin_len     = 3'd0;
    bad_value   = 1'b0;
    res.valid         = 1'b0;
    res.code_point    = '0;
    res.status        = ST_OK;
    res.line_number   = line_ext[OutPosW-1:0];
    res.column_number = col_ext[OutPosW-1:0];

    if (end_of_stream) begin
      // truncated sequence or plain end of stream
      res.valid   = 1'b1;
      res.status  = (exp_len_r != 3'd0) ? ST_MALFORMED : ST_EOS;
      exp_len_nxt = 3'd0;
      seen_nxt    = 3'd0;
      pv_nxt      = '0;
    end else if (exp_len_r == 3'd0) begin
      // leader byte
      if (lead_len == 3'd0) begin
        res.valid  = 1'b1;
        res.status = ST_MALFORMED;
        pv_nxt     = '0;
      end else if (lead_len == 3'd1) begin
        fin     = 1'b1;
        fin_cp  = lead_bits(data_byte);
        fin_len = 3'd1;
      end else begin
        exp_len_nxt = lead_len;
        seen_nxt    = 3'd1;
        pv_nxt      = lead_bits(data_byte);
      end
    end else if (data_byte[7:6] != 2'b10) begin
      // bad continuation, consumed with the partial sequence
      res.valid   = 1'b1;
      res.status  = ST_MALFORMED;
      exp_len_nxt = 3'd0;
      seen_nxt    = 3'd0;
      pv_nxt      = '0;
    end else if ((seen_r + 3'd1) >= exp_len_r) begin
      fin     = 1'b1;
      fin_cp  = cont_pv;
      fin_len = exp_len_r;
    end else begin
      pv_nxt   = cont_pv;
      seen_nxt = seen_r + 3'd1;
    end

    // complete sequence checks and position update
    if (fin) begin
      exp_len_nxt = 3'd0;
      seen_nxt    = 3'd0;
      pv_nxt      = '0;
      bad_value   = (fin_cp > CpMaxValid)
                 || ((fin_cp >= CpSurrLow) && (fin_cp <= CpSurrHigh))
                 || (fin_len != shortest_length(fin_cp));
      res.valid = 1'b1;
      if (bad_value) begin
        res.status = ST_MALFORMED;
      end else if (fin_cp == '0) begin
        res.status = ST_NUL;
      end else begin
        res.status     = ST_OK;
        res.code_point = fin_cp;
        if (fin_cp == CpNewline) begin
          if (line_r != PosMax) begin
            line_nxt = line_r + PosOne;
          end
          col_nxt = PosOne;
        end else if (col_r != PosMax) begin
          col_nxt = col_r + PosOne;
        end
      end
    end
  end

  // state registers, advanced on a decode step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_len_r <= 3'd0;
      seen_r    <= 3'd0;
      pv_r      <= '0;
      line_r    <= PosOne;
      col_r     <= PosOne;
    end else if (step) begin
      exp_len_r <= exp_len_nxt;
      seen_r    <= seen_nxt;
      pv_r      <= pv_nxt;
      line_r    <= line_nxt;
      col_r     <= col_nxt;
    end
  end

`ifndef SYNTH
  // no bytes counted without a pending sequence
  a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (exp_len_r == 3'd0) |-> (seen_r == 3'd0 && pv_r == '0))
    else $error("idle sequence state not clear");

  // a pending sequence is never already complete
  a_pending_short: assert property (@(posedge clk) disable iff (!rst_n)
    (exp_len_r != 3'd0) |-> (seen_r != 3'd0 && seen_r < exp_len_r && exp_len_r <= 3'd4))
    else $error("pending sequence count out of range");

  // error results carry no code point
  a_err_zero_cp: assert property (@(posedge clk) disable iff (!rst_n)
    (step && res.valid && res.status != ST_OK) |-> (res.code_point == '0))
    else $error("error result with nonzero code point");

  // ok results are scalar values
  a_ok_scalar: assert property (@(posedge clk) disable iff (!rst_n)
    (step && res.valid && res.status == ST_OK) |->
      (res.code_point != '0 && res.code_point <= CpMaxValid
       && (res.code_point < CpSurrLow || res.code_point > CpSurrHigh)))
    else $error("ok result outside scalar range");

  // the column only moves on an ok result
  a_col_moves_on_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (col_r != $past(col_r)) |-> $past(step && res.valid && res.status == ST_OK))
    else $error("column changed without an ok result");
`endif

endmodule

// ===== hw/rtl/utfd_out_stage.sv =====
// utfd_out_stage: result register feeding the out_ channel
// depends on utfd_pkg for the result type
module utfd_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  utfd_pkg::result_t res,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [20:0]       out_code_point,
  output logic [1:0]        out_status,
  output logic [31:0]       out_line_number,
  output logic [31:0]       out_column_number
);
  import utfd_pkg::*;

  logic    valid_r, valid_nxt;
  result_t res_r;

  // set on load, cleared when the held transaction is taken
  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload capture
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid         = valid_r;
  assign out_code_point    = res_r.code_point;
  assign out_status        = res_r.status;
  assign out_line_number   = res_r.line_number;
  assign out_column_number = res_r.column_number;

endmodule

// ===== hw/rtl/utf8_decoder_with_position.sv =====
// utf8_decoder_with_position: top level of the UTF-8 decoder with line/column tracking
// depends on utfd_pkg, utfd_in_stage, utfd_decode and utfd_out_stage
//
// Usage:
//   in_ channel: one byte per transaction (in_data_byte), or an end-of-stream
//   marker (in_end_of_stream high, byte ignored). out_ channel: at most one
//   result per input transaction with code point, status (ok, malformed, nul,
//   end of stream) and the line and column where the character starts.
//   Bytes inside a multi-byte sequence give no result until it completes.
//   A result reaches out_ through two registers: the input register holds the
//   accepted byte, then its decode is loaded into the result register.
//   Throughput: one byte per cycle, set by the single-pass decode between the
//   input register and the result register; in_ready stays high while the
//   result register is empty or being drained, and bytes that give no
//   result pass even while a result waits.
//   Stall: when out_ready is low with a result held, a byte whose decode
//   gives a result waits in the input register and in_ready drops.
//   Reset (rst_n low, synchronous): both registers empty, no sequence
//   pending, line and column set to 1. Position counters saturate at the
//   POSITION_WIDTH maximum; out_ ports carry their low 32 bits.
module utf8_decoder_with_position #(
  parameter int POSITION_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_stream,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [20:0] out_code_point,
  output logic [1:0]  out_status,
  output logic [31:0] out_line_number,
  output logic [31:0] out_column_number
);
  import utfd_pkg::*;

  logic       held_valid;
  logic [7:0] held_byte;
  logic       held_eos;
  logic       step;
  result_t    res;

  // decode the held byte when its result, if any, has room
  assign step = held_valid && (!res.valid || !out_valid || out_ready);

  utfd_in_stage u_in (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_end_of_stream (in_end_of_stream),
    .step             (step),
    .held_valid       (held_valid),
    .held_byte        (held_byte),
    .held_eos         (held_eos)
  );

  utfd_decode #(
    .POSITION_WIDTH (POSITION_WIDTH)
  ) u_dec (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (step),
    .data_byte     (held_byte),
    .end_of_stream (held_eos),
    .res           (res)
  );

  utfd_out_stage u_out (
    .clk               (clk),
    .rst_n             (rst_n),
    .load              (step && res.valid),
    .res               (res),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_code_point    (out_code_point),
    .out_status        (out_status),
    .out_line_number   (out_line_number),
    .out_column_number (out_column_number)
  );

`ifndef SYNTH
  // a result never overwrites one that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (step && res.valid) |-> (!out_valid || out_ready))
    else $error("result register overwritten");

  // the decoder only steps on a held transaction
  a_step_held: assert property (@(posedge clk) disable iff (!rst_n)
    step |-> held_valid)
    else $error("decode step without held byte");

  // an end-of-stream marker always produces a result
  a_eos_result: assert property (@(posedge clk) disable iff (!rst_n)
    (step && held_eos) |=> out_valid)
    else $error("end of stream produced no result");
`endif

endmodule
